### design/piezo_christoffel_matrix_top_defines.svh
// Assertion macros for the Christoffel matrix block.
`ifndef PIEZO_CHRISTOFFEL_MATRIX_TOP_DEFINES_SVH
`define PIEZO_CHRISTOFFEL_MATRIX_TOP_DEFINES_SVH

// Checked at every edge outside reset.
`define PCM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pcm check failed");

// Checked at every edge, reset included.
`define PCM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pcm reset check failed");

`endif

### design/pcm_pkg.sv
package pcm_pkg;

    // register indexes
    localparam int NumRegs = 7;
    localparam logic [2:0] RegC11C12 = 3'd0;
    localparam logic [2:0] RegC13C14 = 3'd1;
    localparam logic [2:0] RegC33C44 = 3'd2;
    localparam logic [2:0] RegC66E15 = 3'd3;
    localparam logic [2:0] RegE22E31 = 3'd4;
    localparam logic [2:0] RegE33Eps11 = 3'd5;
    localparam logic [2:0] RegEps33 = 3'd6;

    localparam int QueueDepth = 4;
    localparam int QPtrW = $clog2(QueueDepth);

    // 1/(eps0 * 1e10) = KNum / KDen; KNum carries 8 extra fraction bits
    localparam logic [15:0] KDen = 16'd44271;
    localparam logic [26:0] KNumScaled = 27'd128000000;

    localparam int NumUnits = 6;          // unique (p,s) pairs of the piezo term
    localparam int DivBits = 41;          // quotient bits below the clamp
    localparam logic [41:0] TermLimit = 42'h100_0000_0000;
    localparam int PreStg = 7;            // stages up to the divider start
    localparam int NumStg = PreStg + DivBits + 2;

    typedef struct packed {
        logic signed [15:0] c11;
        logic signed [15:0] c12;
        logic signed [15:0] c13;
        logic signed [15:0] c14;
        logic signed [15:0] c33;
        logic signed [15:0] c44;
        logic signed [15:0] c66;
        logic signed [15:0] e15;
        logic signed [15:0] e22;
        logic signed [15:0] e31;
        logic signed [15:0] e33;
        logic [15:0]        eps11;
        logic [15:0]        eps33;
    } t_coef;

    // queue entry: direction products, weighted permittivity, zero flag
    typedef struct packed {
        logic [8:0][31:0] nn;
        logic [47:0]      epsw;
        logic             zero;
    } t_qent;

    function automatic int voigt(input int i, input int j);
        if (i == j) begin
            return i;
        end
        return 6 - i - j;
    endfunction

    function automatic int pair_p(input int k);
        case (k)
            0, 1, 2: return 0;
            3, 4: return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int pair_s(input int k);
        case (k)
            0: return 0;
            1, 3: return 1;
            default: return 2;
        endcase
    endfunction

    function automatic int pair_idx(input int p, input int s);
        int lo;
        int hi;
        lo = (p < s) ? p : s;
        hi = (p < s) ? s : p;
        if (lo == 0) begin
            return hi;
        end
        if (lo == 1) begin
            return hi + 2;
        end
        return 5;
    endfunction

    // trigonal stiffness in Voigt form
    function automatic logic signed [16:0] cm_coef(input t_coef c, input int a, input int b);
        logic signed [16:0] r;
        r = '0;
        case (a)
            0: begin
                case (b)
                    0: r = 17'(c.c11);
                    1: r = 17'(c.c12);
                    2: r = 17'(c.c13);
                    3: r = 17'(c.c14);
                    default: r = '0;
                endcase
            end
            1: begin
                case (b)
                    0: r = 17'(c.c12);
                    1: r = 17'(c.c11);
                    2: r = 17'(c.c13);
                    3: r = -17'(c.c14);
                    default: r = '0;
                endcase
            end
            2: begin
                case (b)
                    0, 1: r = 17'(c.c13);
                    2: r = 17'(c.c33);
                    default: r = '0;
                endcase
            end
            3: begin
                case (b)
                    0: r = 17'(c.c14);
                    1: r = -17'(c.c14);
                    3: r = 17'(c.c44);
                    default: r = '0;
                endcase
            end
            4: begin
                case (b)
                    4: r = 17'(c.c44);
                    5: r = 17'(c.c14);
                    default: r = '0;
                endcase
            end
            default: begin
                case (b)
                    4: r = 17'(c.c14);
                    5: r = 17'(c.c66);
                    default: r = '0;
                endcase
            end
        endcase
        return r;
    endfunction

    // trigonal piezo tensor in Voigt form, row q
    function automatic logic signed [16:0] pe_coef(input t_coef c, input int q, input int b);
        logic signed [16:0] r;
        r = '0;
        case (q)
            0: begin
                case (b)
                    4: r = 17'(c.e15);
                    5: r = -17'(c.e22);
                    default: r = '0;
                endcase
            end
            1: begin
                case (b)
                    0: r = -17'(c.e22);
                    1: r = 17'(c.e22);
                    3: r = 17'(c.e15);
                    default: r = '0;
                endcase
            end
            default: begin
                case (b)
                    0, 1: r = 17'(c.e31);
                    2: r = 17'(c.e33);
                    default: r = '0;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

### design/pcm_in_if.sv
interface pcm_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;

    modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
    modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

### design/pcm_out_if.sv
interface pcm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] g_xx;
    logic signed [31:0] g_xy;
    logic signed [31:0] g_xz;
    logic signed [31:0] g_yx;
    logic signed [31:0] g_yy;
    logic signed [31:0] g_yz;
    logic signed [31:0] g_zx;
    logic signed [31:0] g_zy;
    logic signed [31:0] g_zz;
    logic               eps_zero;

    modport source (output valid, output g_xx, output g_xy, output g_xz, output g_yx,
                    output g_yy, output g_yz, output g_zx, output g_zy, output g_zz,
                    output eps_zero, input ready);
    modport sink (input valid, input g_xx, input g_xy, input g_xz, input g_yx,
                  input g_yy, input g_yz, input g_zx, input g_zy, input g_zz,
                  input eps_zero, output ready);
endinterface

### design/pcm_front.sv
module pcm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pcm_pkg::t_coef i_coef,
    pcm_in_if.sink         i_in,
    input  logic           i_q_full,
    output logic           o_push,
    output pcm_pkg::t_qent o_entry
);

    logic             r_valid;
    logic [8:0][31:0] r_nn;
    logic signed [31:0] w_dir [3];
    logic             w_acc;
    logic [31:0]      w_sum;
    logic [47:0]      w_epsw;

    assign w_dir[0] = 32'(i_in.dir_x);
    assign w_dir[1] = 32'(i_in.dir_y);
    assign w_dir[2] = 32'(i_in.dir_z);

    assign i_in.ready = !r_valid || !i_q_full;
    assign w_acc = i_in.valid && i_in.ready;
    assign o_push = r_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_acc) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // all nine direction products; the products fit 32 bits signed
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            for (int q = 0; q < 3; q++) begin
                for (int r = 0; r < 3; r++) begin
                    r_nn[q*3+r] <= w_dir[q] * w_dir[r];
                end
            end
        end
    end

    // squares are non-negative, so their sum fits 32 bits unsigned
    assign w_sum = r_nn[0] + r_nn[4];
    assign w_epsw = 48'(i_coef.eps11) * 48'(w_sum) + 48'(i_coef.eps33) * 48'(r_nn[8]);

    assign o_entry.nn = r_nn;
    assign o_entry.epsw = w_epsw;
    assign o_entry.zero = (w_epsw == 48'd0);

endmodule

### design/pcm_queue.sv
module pcm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pcm_pkg::t_qent i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output pcm_pkg::t_qent o_data
);

    pcm_pkg::t_qent r_mem [pcm_pkg::QueueDepth];
    logic [pcm_pkg::QPtrW-1:0] r_wr;
    logic [pcm_pkg::QPtrW-1:0] r_rd;
    logic [pcm_pkg::QPtrW:0]   r_cnt;
    logic w_push;
    logic w_pop;

    assign o_full = (r_cnt == (pcm_pkg::QPtrW + 1)'(pcm_pkg::QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_data = r_mem[r_rd];
    assign w_push = i_push && !o_full;
    assign w_pop = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10: r_cnt <= r_cnt + 1'b1;
                2'b01: r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### design/pcm_back.sv
module pcm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pcm_pkg::t_coef i_coef,
    input  logic           i_q_valid,
    input  pcm_pkg::t_qent i_q_data,
    output logic           o_pop,
    pcm_out_if.source      o_out
);

    // data that rides along the divider
    typedef struct packed {
        logic [8:0][39:0]                g;
        logic [63:0]                     den;
        logic                            zero;
        logic [pcm_pkg::NumUnits-1:0]    neg;
        logic [pcm_pkg::NumUnits-1:0]    ovf;
    } t_side;

    typedef struct packed {
        logic [63:0] rem;
        logic [pcm_pkg::DivBits-1:0] q;
        logic [pcm_pkg::DivBits-1:0] nlow;
    } t_div;

    function automatic t_div div_step(input t_div d, input logic [63:0] den);
        t_div r;
        logic [64:0] x;
        logic ge;
        x = {d.rem, d.nlow[pcm_pkg::DivBits-1]};
        ge = (x >= {1'b0, den});
        r.rem = ge ? 64'(x - {1'b0, den}) : x[63:0];
        r.q = {d.q[pcm_pkg::DivBits-2:0], ge};
        r.nlow = {d.nlow[pcm_pkg::DivBits-2:0], 1'b0};
        return r;
    endfunction

    logic [pcm_pkg::NumStg-1:0] r_vld;
    logic w_en;

    // stage 0: products
    logic signed [48:0] r1_gp [9][9];
    logic signed [48:0] r1_ap [3][9];
    logic [39:0] r1_den_lo;
    logic [39:0] r1_den_hi;
    logic        r1_zero;
    // stage 1: partial sums
    logic signed [50:0] r2_gps [9][3];
    logic signed [50:0] r2_aps [3][3];
    logic [63:0] r2_den;
    logic        r2_zero;
    // stage 2: rounded G and gamma
    logic signed [53:0] w_gs [9];
    logic signed [53:0] w_as [3];
    logic signed [39:0] r3_g [9];
    logic signed [31:0] r3_gam [3];
    logic [63:0] r3_den;
    logic        r3_zero;
    // stage 3..5: |gp*gs| and numerator
    logic [30:0] w_mag [3];
    logic [61:0] r4_prod [pcm_pkg::NumUnits];
    t_side       r4_side;
    logic [57:0] r5_nhi [pcm_pkg::NumUnits];
    logic [57:0] r5_nlo [pcm_pkg::NumUnits];
    t_side       r5_side;
    logic [88:0] r6_n [pcm_pkg::NumUnits];
    t_side       r6_side;
    // divider
    t_div        r_div [pcm_pkg::DivBits+1][pcm_pkg::NumUnits];
    t_side       r_side [pcm_pkg::DivBits+1];
    // rounding and output
    logic [40:0] r_term [pcm_pkg::NumUnits];
    t_side       r_tside;
    logic signed [31:0] r_out [9];
    logic        r_ezero;

    assign w_en = !r_vld[pcm_pkg::NumStg-1] || o_out.ready;
    assign o_pop = w_en && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[pcm_pkg::NumStg-2:0], i_q_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int p = 0; p < 3; p++) begin
                for (int s = 0; s < 3; s++) begin
                    for (int q = 0; q < 3; q++) begin
                        for (int r = 0; r < 3; r++) begin
                            r1_gp[p*3+s][q*3+r] <= 49'(pcm_pkg::cm_coef(i_coef,
                                pcm_pkg::voigt(p, q), pcm_pkg::voigt(r, s)))
                                * 49'($signed(i_q_data.nn[q*3+r]));
                        end
                    end
                end
            end
            for (int p = 0; p < 3; p++) begin
                for (int q = 0; q < 3; q++) begin
                    for (int r = 0; r < 3; r++) begin
                        r1_ap[p][q*3+r] <= 49'(pcm_pkg::pe_coef(i_coef, q,
                            pcm_pkg::voigt(p, r))) * 49'($signed(i_q_data.nn[q*3+r]));
                    end
                end
            end
            r1_den_lo <= 40'(i_q_data.epsw[23:0]) * 40'(pcm_pkg::KDen);
            r1_den_hi <= 40'(i_q_data.epsw[47:24]) * 40'(pcm_pkg::KDen);
            r1_zero <= i_q_data.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 9; e++) begin
                for (int q = 0; q < 3; q++) begin
                    r2_gps[e][q] <= 51'(r1_gp[e][q*3]) + 51'(r1_gp[e][q*3+1])
                                  + 51'(r1_gp[e][q*3+2]);
                end
            end
            for (int p = 0; p < 3; p++) begin
                for (int q = 0; q < 3; q++) begin
                    r2_aps[p][q] <= 51'(r1_ap[p][q*3]) + 51'(r1_ap[p][q*3+1])
                                  + 51'(r1_ap[p][q*3+2]);
                end
            end
            r2_den <= {r1_den_hi, 24'd0} + 64'(r1_den_lo);
            r2_zero <= r1_zero;
        end
    end

    // round half up at bit 18
    always_comb begin
        for (int e = 0; e < 9; e++) begin
            w_gs[e] = 54'(r2_gps[e][0]) + 54'(r2_gps[e][1]) + 54'(r2_gps[e][2])
                    + 54'sh20000;
        end
        for (int p = 0; p < 3; p++) begin
            w_as[p] = 54'(r2_aps[p][0]) + 54'(r2_aps[p][1]) + 54'(r2_aps[p][2])
                    + 54'sh20000;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int e = 0; e < 9; e++) begin
                r3_g[e] <= 40'(w_gs[e] >>> 18);
            end
            for (int p = 0; p < 3; p++) begin
                r3_gam[p] <= 32'(w_as[p] >>> 18);
            end
            r3_den <= r2_den;
            r3_zero <= r2_zero;
        end
    end

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            w_mag[p] = r3_gam[p][31] ? 31'(-r3_gam[p]) : 31'(r3_gam[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                r4_prod[k] <= 62'(w_mag[pcm_pkg::pair_p(k)]) * 62'(w_mag[pcm_pkg::pair_s(k)]);
                r4_side.neg[k] <= r3_gam[pcm_pkg::pair_p(k)][31]
                                ^ r3_gam[pcm_pkg::pair_s(k)][31];
            end
            for (int e = 0; e < 9; e++) begin
                r4_side.g[e] <= r3_g[e];
            end
            r4_side.den <= r3_den;
            r4_side.zero <= r3_zero;
            r4_side.ovf <= '0;
        end
    end

    // numerator times the scaled constant, split in two halves
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                r5_nhi[k] <= 58'(r4_prod[k][61:31]) * 58'(pcm_pkg::KNumScaled);
                r5_nlo[k] <= 58'(r4_prod[k][30:0]) * 58'(pcm_pkg::KNumScaled);
            end
            r5_side <= r4_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                r6_n[k] <= {r5_nhi[k], 31'd0} + 89'(r5_nlo[k]);
            end
            r6_side <= r5_side;
        end
    end

    // divider start: quotient at or above 2^41 is clamped anyway
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                r_div[0][k].rem <= 64'(r6_n[k][88:41]);
                r_div[0][k].q <= '0;
                r_div[0][k].nlow <= r6_n[k][40:0];
            end
            r_side[0].g <= r6_side.g;
            r_side[0].den <= r6_side.den;
            r_side[0].zero <= r6_side.zero;
            r_side[0].neg <= r6_side.neg;
            for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                r_side[0].ovf[k] <= (64'(r6_n[k][88:41]) >= r6_side.den);
            end
        end
    end

    // one quotient bit per stage
    for (genvar st = 1; st <= pcm_pkg::DivBits; st++) begin : g_div
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                    r_div[st][k] <= div_step(r_div[st-1][k], r_side[st-1].den);
                end
                r_side[st] <= r_side[st-1];
            end
        end
    end

    // round half away from zero on the magnitude, then clamp
    always_ff @(posedge i_clk) begin
        logic [41:0] rnd;
        logic        inc;
        if (w_en) begin
            for (int k = 0; k < pcm_pkg::NumUnits; k++) begin
                inc = (r_div[pcm_pkg::DivBits][k].rem
                      >= r_side[pcm_pkg::DivBits].den - r_div[pcm_pkg::DivBits][k].rem);
                rnd = 42'(r_div[pcm_pkg::DivBits][k].q) + 42'(inc);
                if (r_side[pcm_pkg::DivBits].ovf[k] || rnd > pcm_pkg::TermLimit) begin
                    r_term[k] <= 41'(pcm_pkg::TermLimit);
                end else begin
                    r_term[k] <= 41'(rnd);
                end
            end
            r_tside <= r_side[pcm_pkg::DivBits];
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [42:0] trm;
        logic signed [42:0] tot;
        int u;
        if (w_en) begin
            for (int p = 0; p < 3; p++) begin
                for (int s = 0; s < 3; s++) begin
                    u = pcm_pkg::pair_idx(p, s);
                    trm = r_tside.neg[u] ? -$signed(43'(r_term[u])) : $signed(43'(r_term[u]));
                    tot = 43'($signed(r_tside.g[p*3+s])) + (r_tside.zero ? 43'sd0 : trm);
                    if (tot > 43'sd2147483647) begin
                        r_out[p*3+s] <= 32'sh7fffffff;
                    end else if (tot < -43'sd2147483648) begin
                        r_out[p*3+s] <= 32'sh80000000;
                    end else begin
                        r_out[p*3+s] <= tot[31:0];
                    end
                end
            end
            r_ezero <= r_tside.zero;
        end
    end

    assign o_out.valid = r_vld[pcm_pkg::NumStg-1];
    assign o_out.g_xx = r_out[0];
    assign o_out.g_xy = r_out[1];
    assign o_out.g_xz = r_out[2];
    assign o_out.g_yx = r_out[3];
    assign o_out.g_yy = r_out[4];
    assign o_out.g_yz = r_out[5];
    assign o_out.g_zx = r_out[6];
    assign o_out.g_zy = r_out[7];
    assign o_out.g_zz = r_out[8];
    assign o_out.eps_zero = r_ezero;

endmodule

### design/piezo_christoffel_matrix_top.sv
// Path: front product register, queue, back pipeline; the long pole is the 41-stage
//   restoring divider, one quotient bit per stage, six units in parallel (one per
//   unique element pair). Throughput: one item per cycle unless the output stalls.
// Reset: i_rst_n is synchronous, active low; it clears all valid flags, the queue
//   pointers and the seven coefficient registers. No clearing pass is needed.
module piezo_christoffel_matrix_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pcm_in_if.sink      i_in,
    pcm_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Coefficient registers; register i sits at byte address 4*i.
    logic [31:0] r_cfg [pcm_pkg::NumRegs];
    logic [2:0]  w_idx;
    logic        w_wr;
    pcm_pkg::t_coef w_coef;

    // Front to queue, queue to back
    logic           w_push;
    logic           w_full;
    pcm_pkg::t_qent w_fentry;
    logic           w_qvalid;
    logic           w_pop;
    pcm_pkg::t_qent w_qentry;

    assign pready = 1'b1;
    assign w_idx = paddr[4:2];
    assign w_wr = psel && penable && pwrite && pready;

    // Writes past the last register are dropped; eps33 keeps only 16 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < pcm_pkg::NumRegs; i++) begin
                r_cfg[i] <= '0;
            end
        end else if (w_wr) begin
            case (w_idx)
                pcm_pkg::RegC11C12, pcm_pkg::RegC13C14, pcm_pkg::RegC33C44,
                pcm_pkg::RegC66E15, pcm_pkg::RegE22E31, pcm_pkg::RegE33Eps11: begin
                    r_cfg[w_idx] <= pwdata;
                end
                pcm_pkg::RegEps33: begin
                    r_cfg[pcm_pkg::RegEps33] <= {16'd0, pwdata[15:0]};
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            pcm_pkg::RegC11C12, pcm_pkg::RegC13C14, pcm_pkg::RegC33C44,
            pcm_pkg::RegC66E15, pcm_pkg::RegE22E31, pcm_pkg::RegE33Eps11,
            pcm_pkg::RegEps33: prdata = r_cfg[w_idx];
            default: prdata = '0;
        endcase
    end

    // Unpack the coefficient pairs: first one in the high half.
    assign w_coef.c11 = r_cfg[pcm_pkg::RegC11C12][31:16];
    assign w_coef.c12 = r_cfg[pcm_pkg::RegC11C12][15:0];
    assign w_coef.c13 = r_cfg[pcm_pkg::RegC13C14][31:16];
    assign w_coef.c14 = r_cfg[pcm_pkg::RegC13C14][15:0];
    assign w_coef.c33 = r_cfg[pcm_pkg::RegC33C44][31:16];
    assign w_coef.c44 = r_cfg[pcm_pkg::RegC33C44][15:0];
    assign w_coef.c66 = r_cfg[pcm_pkg::RegC66E15][31:16];
    assign w_coef.e15 = r_cfg[pcm_pkg::RegC66E15][15:0];
    assign w_coef.e22 = r_cfg[pcm_pkg::RegE22E31][31:16];
    assign w_coef.e31 = r_cfg[pcm_pkg::RegE22E31][15:0];
    assign w_coef.e33 = r_cfg[pcm_pkg::RegE33Eps11][31:16];
    assign w_coef.eps11 = r_cfg[pcm_pkg::RegE33Eps11][15:0];
    assign w_coef.eps33 = r_cfg[pcm_pkg::RegEps33][15:0];

    // Front: takes the direction, forms n_q*n_r and the weighted permittivity,
    // and flags a zero permittivity.
    pcm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_coef   (w_coef),
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_entry  (w_fentry)
    );

    // Short queue so the front keeps taking items while the back is stalled.
    pcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fentry),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_data  (w_qentry)
    );

    // Back: elastic and piezo sums, piezo term divider, saturation,
    // output register. The whole back pipe holds when its output is stalled.
    pcm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_coef    (w_coef),
        .i_q_valid (w_qvalid),
        .i_q_data  (w_qentry),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

### design/pcm_checker.sv
`include "piezo_christoffel_matrix_top_defines.svh"

module pcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_g_xx,
    input logic [31:0] i_g_xy,
    input logic [31:0] i_g_xz,
    input logic [31:0] i_g_yx,
    input logic [31:0] i_g_yz,
    input logic [31:0] i_g_zx,
    input logic [31:0] i_g_zy,
    input logic [31:0] i_g_zz,
    input logic        i_eps_zero
);

    // stalled result holds
    `PCM_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_g_xx) && $stable(i_g_zz) && $stable(i_eps_zero))

    // the stiffened matrix is symmetric
    `PCM_ASSERT(a_symmetric, i_clk, i_rst_n, i_out_valid |-> i_g_xy == i_g_yx && i_g_xz == i_g_zx && i_g_yz == i_g_zy)

    // reset empties the pipe and frees the input
    `PCM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_out_valid && i_in_ready)

endmodule

bind piezo_christoffel_matrix_top pcm_checker u_pcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_g_xx      (o_out.g_xx),
    .i_g_xy      (o_out.g_xy),
    .i_g_xz      (o_out.g_xz),
    .i_g_yx      (o_out.g_yx),
    .i_g_yz      (o_out.g_yz),
    .i_g_zx      (o_out.g_zx),
    .i_g_zy      (o_out.g_zy),
    .i_g_zz      (o_out.g_zz),
    .i_eps_zero  (o_out.eps_zero)
);

### tb/sv/tb_pcm_checker.sv
`timescale 1ns / 1ps
module tb_pcm_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    pcm_in_if     i_in,
    pcm_out_if    i_out,
    input  logic  psel,
    input  logic  penable,
    input  logic  pwrite,
    input  logic  pready,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output int    o_fail_cnt,
    output int    o_pending
);
    import pcm_pkg::*;

    typedef struct {
        logic signed [31:0] g[9];
        logic               zero;
    } t_matrix;

    logic [31:0] coef_regs[NumRegs];
    t_matrix     matrix_q[$];

    assign o_pending = matrix_q.size();

    function automatic logic signed [63:0] sx16(input logic [15:0] v);
        return 64'(signed'(v));
    endfunction

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic int vmap(input int i, input int j);
        return (i == j) ? i : 6 - i - j;
    endfunction

    // rounded a*KNumScaled/d, half away from zero, clamped at 2^40
    function automatic logic [63:0] piezo_quot(input logic [63:0] a, input logic [63:0] d);
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] r;
        num = 128'(a) * 128'(KNumScaled);
        q = num / 128'(d);
        r = num % 128'(d);
        if (r >= 128'(d) - r) q = q + 1;
        if (q > 128'(TermLimit)) q = 128'(TermLimit);
        return q[63:0];
    endfunction

    function automatic t_matrix predict_matrix(input logic [15:0] dx, input logic [15:0] dy,
                                               input logic [15:0] dz);
        logic signed [63:0] c11, c12, c13, c14, c33, c44, c66, e15, e22, e31, e33;
        logic signed [63:0] cm[6][6];
        logic signed [63:0] pe[3][6];
        logic signed [63:0] n[3];
        logic signed [63:0] nn[3][3];
        logic signed [63:0] gam[3];
        logic signed [63:0] acc, tot, term;
        logic [63:0] epsw, den, ma, mb;
        t_matrix m;
        c11 = sx16(coef_regs[0][31:16]); c12 = sx16(coef_regs[0][15:0]);
        c13 = sx16(coef_regs[1][31:16]); c14 = sx16(coef_regs[1][15:0]);
        c33 = sx16(coef_regs[2][31:16]); c44 = sx16(coef_regs[2][15:0]);
        c66 = sx16(coef_regs[3][31:16]); e15 = sx16(coef_regs[3][15:0]);
        e22 = sx16(coef_regs[4][31:16]); e31 = sx16(coef_regs[4][15:0]);
        e33 = sx16(coef_regs[5][31:16]);
        foreach (cm[a, b]) cm[a][b] = 0;
        foreach (pe[a, b]) pe[a][b] = 0;
        cm[0][0] = c11; cm[0][1] = c12; cm[0][2] = c13; cm[0][3] = c14;
        cm[1][0] = c12; cm[1][1] = c11; cm[1][2] = c13; cm[1][3] = -c14;
        cm[2][0] = c13; cm[2][1] = c13; cm[2][2] = c33;
        cm[3][0] = c14; cm[3][1] = -c14; cm[3][3] = c44;
        cm[4][4] = c44; cm[4][5] = c14; cm[5][4] = c14; cm[5][5] = c66;
        pe[0][4] = e15; pe[0][5] = -e22;
        pe[1][0] = -e22; pe[1][1] = e22; pe[1][3] = e15;
        pe[2][0] = e31; pe[2][1] = e31; pe[2][2] = e33;
        n[0] = sx16(dx); n[1] = sx16(dy); n[2] = sx16(dz);
        foreach (nn[q, r]) nn[q][r] = n[q] * n[r];
        for (int p = 0; p < 3; p++) begin
            acc = 0;
            for (int q = 0; q < 3; q++)
                for (int r = 0; r < 3; r++) acc += pe[q][vmap(p, r)] * nn[q][r];
            gam[p] = rnd_shift(acc, 18);
        end
        epsw = 64'(coef_regs[5][15:0]) * 64'(nn[0][0] + nn[1][1])
             + 64'(coef_regs[6][15:0]) * 64'(nn[2][2]);
        m.zero = (epsw == 0);
        den = 64'(KDen) * epsw;
        for (int p = 0; p < 3; p++) begin
            for (int s = 0; s < 3; s++) begin
                acc = 0;
                for (int q = 0; q < 3; q++)
                    for (int r = 0; r < 3; r++)
                        acc += cm[vmap(p, q)][vmap(r, s)] * nn[q][r];
                tot = rnd_shift(acc, 18);
                if (!m.zero) begin
                    ma = (gam[p] < 0) ? -gam[p] : gam[p];
                    mb = (gam[s] < 0) ? -gam[s] : gam[s];
                    term = piezo_quot(ma * mb, den);
                    if ((gam[p] < 0) != (gam[s] < 0)) term = -term;
                    tot += term;
                end
                if (tot > 64'sd2147483647) tot = 64'sd2147483647;
                if (tot < -64'sd2147483648) tot = -64'sd2147483648;
                m.g[p * 3 + s] = tot[31:0];
            end
        end
        return m;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_cnt++;
    endtask

    always @(posedge i_clk) begin
        logic [31:0] got[9];
        t_matrix want;
        if (!i_rst_n) begin
            foreach (coef_regs[i]) coef_regs[i] <= '0;
            o_fail_cnt = 0;
        end else begin
            // registers update at the access edge; input sees the old values
            if (i_in.valid && i_in.ready)
                matrix_q.push_back(predict_matrix(i_in.dir_x, i_in.dir_y, i_in.dir_z));
            if (psel && penable && pwrite && pready) begin
                if (paddr[4:2] == RegEps33) coef_regs[RegEps33] <= {16'h0, pwdata[15:0]};
                else if (paddr[4:2] < NumRegs) coef_regs[paddr[4:2]] <= pwdata;
            end
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.g_xx, i_out.g_xy, i_out.g_xz, i_out.g_yx, i_out.g_yy,
                        i_out.g_yz, i_out.g_zx, i_out.g_zy, i_out.g_zz};
                if (matrix_q.size() == 0) begin
                    report_mismatch("unexpected item", 32'd0, 32'd0);
                end else begin
                    want = matrix_q.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (got[k] !== want.g[k]) report_mismatch($sformatf("g[%0d]", k),
                                                                  got[k], want.g[k]);
                    if (i_out.eps_zero !== want.zero)
                        report_mismatch("eps_zero", 32'(i_out.eps_zero), 32'(want.zero));
                end
            end
        end
    end
endmodule

### tb/sv/tb_piezo_christoffel_matrix_top.sv
`timescale 1ns / 1ps
module tb_piezo_christoffel_matrix_top;
    import pcm_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_cnt;
    int          pending;
    int          stall_mode;

    pcm_in_if  dir_ch ();
    pcm_out_if mat_ch ();

    always #1 i_clk = ~i_clk;

    piezo_christoffel_matrix_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (dir_ch.sink),
        .o_out   (mat_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tb_pcm_checker u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (dir_ch),
        .i_out      (mat_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .pready     (pready),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    initial begin
        dir_ch.valid = 1'b0;
        dir_ch.dir_x = '0;
        dir_ch.dir_y = '0;
        dir_ch.dir_z = '0;
        mat_ch.ready = 1'b0;
    end

    // Receiver stall pattern: mode changes now and then; mode 0 never stalls,
    // mode 1 stalls lightly, mode 2 heavily, mode 3 in long periodic runs.
    always @(negedge i_clk) begin
        int cyc;
        cyc++;
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0: mat_ch.ready <= 1'b1;
            1: mat_ch.ready <= ($urandom_range(0, 3) != 0);
            2: mat_ch.ready <= ($urandom_range(0, 3) == 0);
            default: mat_ch.ready <= ((cyc % 37) > 12);
        endcase
    end

    // APB write: setup cycle, then access cycle; the register takes the
    // value at the access edge (pready is tied high in the block).
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic load_coefs(input logic [31:0] v[NumRegs]);
        for (int i = 0; i < NumRegs; i++) write_reg(3'(i), v[i]);
    endtask

    // Send one direction; valid stays high from item to item in a burst.
    task automatic send_dir(input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input bit keep);
        dir_ch.valid <= 1'b1;
        dir_ch.dir_x <= x; dir_ch.dir_y <= y; dir_ch.dir_z <= z;
        @(posedge i_clk);
        while (!dir_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (!keep) dir_ch.valid <= 1'b0;
    endtask

    // Wait for every matrix to drain, plus the pipeline depth.
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    function automatic logic [15:0] pick_dir();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'(signed'($urandom_range(0, 31)) - 16);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int cnt);
        int left;
        int burst;
        logic [15:0] x, y, z;
        left = cnt;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left) burst = left;
            for (int b = 0; b < burst; b++) begin
                x = pick_dir(); y = pick_dir(); z = pick_dir();
                // some directions in the xy plane or on an axis
                if ($urandom_range(0, 9) == 0) z = '0;
                if ($urandom_range(0, 14) == 0) begin x = '0; y = '0; end
                send_dir(x, y, z, b != burst - 1);
            end
            left -= burst;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    initial begin
        logic [31:0] cfg[NumRegs];
        stall_mode = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset coefficients: everything zero, eps is zero too
        send_dir(16'h4000, 16'h2000, 16'h1000, 1'b0);
        drain();

        // typical quartz-like values
        cfg = '{{16'sd22, 16'sd2}, {16'sd3, -16'sd5}, {16'sd27, 16'sd15},
                {16'sd10, 16'h0200}, {16'h0800, 16'hF900}, {16'h1000, 16'd300},
                32'd400};
        load_coefs(cfg);
        // directed: axes, extremes, zero direction, mixed signs
        send_dir(16'h7FFF, 16'h0000, 16'h0000, 1'b1);
        send_dir(16'h0000, 16'h7FFF, 16'h0000, 1'b1);
        send_dir(16'h0000, 16'h0000, 16'h7FFF, 1'b1);
        send_dir(16'h8000, 16'h8000, 16'h8000, 1'b1);
        send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_dir(16'h8000, 16'h7FFF, 16'h0001, 1'b1);
        send_dir(16'h0000, 16'h0000, 16'h0000, 1'b1);
        send_dir(16'h5A82, 16'hA57E, 16'h0000, 1'b1);
        send_dir(16'h0001, 16'hFFFF, 16'h0001, 1'b0);
        drain();

        // tiny eps with huge piezo: clamped term and saturation
        cfg = '{32'h7FFF_8000, 32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                32'h7FFF_8000, 32'h8000_0001, 32'h0000_0001};
        load_coefs(cfg);
        send_dir(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
        send_dir(16'h8000, 16'h0000, 16'h7FFF, 1'b1);
        send_dir(16'h0001, 16'h0000, 16'h0000, 1'b1);
        send_dir(16'h0000, 16'h0000, 16'h0001, 1'b1);
        send_dir(16'h8000, 16'h8000, 16'h0000, 1'b0);
        drain();

        // eps11 zero, eps33 nonzero: zero flag only for directions in the plane
        cfg = '{32'h8000_8000, 32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                32'h8000_8000, 32'h8000_0000, 32'h0000_FFFF};
        load_coefs(cfg);
        send_dir(16'h7FFF, 16'h8000, 16'h0000, 1'b1);
        send_dir(16'h7FFF, 16'h8000, 16'h0010, 1'b1);
        send_dir(16'h8000, 16'h8000, 16'h8000, 1'b0);
        drain();

        // random phases over random coefficient sets, with a max-eps set too
        for (int ph = 0; ph < 6; ph++) begin
            foreach (cfg[i]) cfg[i] = $urandom;
            if (ph == 2) begin cfg[5][15:0] = 16'hFFFF; cfg[6] = 32'h0000_FFFF; end
            if (ph == 4) begin cfg[5][15:0] = 16'h0000; cfg[6] = $urandom_range(0, 3); end
            load_coefs(cfg);
            random_phase(255);
            drain();
        end

        while (pending != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
